FILE: hw/rtl/tagged_history_branch_predictor_defines.svh
// Assertion macros shared by the branch predictor RTL.
`ifndef TAGGED_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH
`define TAGGED_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, held off while in reset.
`define THBP_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, held off while in reset.
`define THBP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/thbp_pkg.sv
// Types, constants and helper functions for the tagged history branch predictor.
`default_nettype none
package thbp_pkg;

    localparam int NUM_TAGGED = 4;

    localparam logic       OP_PREDICT  = 1'b0;
    localparam logic       OP_UPDATE   = 1'b1;

    localparam logic [2:0] CTR_MAX     = 3'd7;
    localparam logic [2:0] CTR_WEAK_T  = 3'd4;
    localparam logic [2:0] CTR_WEAK_NT = 3'd3;

    localparam logic [2:0] PROV_BIMODAL = 3'd0;
    localparam logic [2:0] PROV_LAST    = 3'd4;

    localparam logic [15:0] LFSR_SEED  = 16'hACE1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    // Fibonacci LFSR, taps 16/14/13/11, shifting right.
    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[15:1]};
    endfunction

    // Remainder by three: sum of base-4 digits, folded twice.
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] s2;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (s2 >= 3'd6) begin
            s2 = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            s2 = s2 - 3'd3;
        end
        return s2[1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/thbp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module thbp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tagged_history_branch_predictor.sv
// Top level of the tagged history (PPM style) branch predictor.
// Tables are read on accept; LOOK then compares, writes back and loads the
// output register. No new item is taken in LOOK or while a result waits on m_ready.
// Reset: synchronous, active low; a clearing pass then writes every table entry,
// stepping through 2^max(BIMODAL_INDEX_BITS, TABLE_INDEX_BITS) addresses,
// during which no item is taken.
`default_nettype none
`include "tagged_history_branch_predictor_defines.svh"
module tagged_history_branch_predictor #(
    parameter int TABLE_INDEX_BITS   = 9,
    parameter int BIMODAL_INDEX_BITS = 11,
    parameter int TAG_BITS           = 8,
    parameter int LONGEST_HISTORY    = 80
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [31:0] s_pc,
    input  wire logic        s_resolved_taken,
    input  wire logic        s_predicted_taken,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_predict_taken,
    output logic [2:0]       m_provider
);

    localparam int NT       = thbp_pkg::NUM_TAGGED;
    localparam int TI       = TABLE_INDEX_BITS;
    localparam int BI       = BIMODAL_INDEX_BITS;
    localparam int EW       = TAG_BITS + 4;          // {ctr[2:0], tag, u}
    localparam int BW       = 4;                     // {meta, ctr[2:0]}
    localparam int CLR_BITS = (BI > TI) ? BI : TI;

    typedef logic [TI-1:0]       slot_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [EW-1:0]       entry_t;

    // ------------------------------------------------------------------
    // Control and item registers
    // ------------------------------------------------------------------
    thbp_pkg::state_t state_reg, state_next;
    logic [CLR_BITS-1:0] clr_reg;

    logic        op_reg;
    logic [31:0] pc_reg;
    logic        taken_reg;
    logic        guess_reg;
    slot_t       slot_reg [NT];

    // Speculative-free history: only updates shift it.
    logic [LONGEST_HISTORY-1:0] hist_reg;
    tag_t                  fold_tag_reg  [NT];
    tag_t                  fold_tag_next [NT];
    logic [TAG_BITS-2:0]   fold_tag2_reg [NT];
    logic [TAG_BITS-2:0]   fold_tag2_next[NT];
    slot_t                 fold_idx_reg  [NT];
    slot_t                 fold_idx_next [NT];

    // Provider latched by the last predict, trained by the next update.
    logic [2:0]  pend_prov_reg;
    slot_t       pend_slot_reg;
    logic [15:0] lfsr_reg;

    logic        m_valid_reg;
    logic        m_taken_reg;
    logic [2:0]  m_prov_reg;

    logic accept;
    logic look;

    assign s_ready         = (state_reg == thbp_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept          = s_valid && s_ready;
    assign look            = (state_reg == thbp_pkg::ST_LOOK);
    assign m_valid         = m_valid_reg;
    assign m_predict_taken = m_taken_reg;
    assign m_provider      = m_prov_reg;

    // ------------------------------------------------------------------
    // Read address generation (accept cycle)
    // ------------------------------------------------------------------
    slot_t calc_slot [NT];
    slot_t rd_addr   [NT];

    always_comb begin
        for (int t = 0; t < NT; t++) begin
            calc_slot[t] = s_pc[TI-1:0] ^ slot_t'(s_pc >> (TI - t)) ^ fold_idx_reg[t];
            // On update the provider's own table is read at the latched slot.
            if (s_opcode == thbp_pkg::OP_UPDATE && pend_prov_reg == 3'(t + 1)) begin
                rd_addr[t] = pend_slot_reg;
            end else begin
                rd_addr[t] = calc_slot[t];
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [BW-1:0] bim_rd;
    logic          bim_we;
    logic [BI-1:0] bim_wa;
    logic [BW-1:0] bim_wd;

    entry_t tag_rd [NT];
    logic   tag_we [NT];
    slot_t  tag_wa [NT];
    entry_t tag_wd [NT];

    thbp_ram #(.WIDTH(BW), .DEPTH(1 << BI)) u_bim_ram (
        .aclk  (aclk),
        .we    (bim_we),
        .waddr (bim_wa),
        .wdata (bim_wd),
        .re    (accept),
        .raddr (s_pc[BI-1:0]),
        .rdata (bim_rd)
    );

    for (genvar t = 0; t < NT; t++) begin : g_tbl
        thbp_ram #(.WIDTH(EW), .DEPTH(1 << TI)) u_tag_ram (
            .aclk  (aclk),
            .we    (tag_we[t]),
            .waddr (tag_wa[t]),
            .wdata (tag_wd[t]),
            .re    (accept),
            .raddr (rd_addr[t]),
            .rdata (tag_rd[t])
        );
    end

    // ------------------------------------------------------------------
    // Lookup / training (LOOK cycle)
    // ------------------------------------------------------------------
    tag_t       calc_tag [NT];
    logic [2:0] hit_prov;
    logic       hit_dir;

    logic [2:0]  prov;
    logic [1:0]  pidx;
    logic [2:0]  cur_ctr;
    logic [2:0]  trained;
    logic [2:0]  bim_ctr_t;
    logic        bdir;
    logic        alloc;
    logic        all_used;
    logic [15:0] lfsr_adv;
    logic [1:0]  off;
    logic [2:0]  pick;
    logic [NT-1:0] claim;
    logic        claim_dir;
    logic        useful_upd;
    logic        uval;

    always_comb begin
        // longest matching table wins
        hit_prov = thbp_pkg::PROV_BIMODAL;
        hit_dir  = bim_rd[2:0] > thbp_pkg::CTR_WEAK_NT;
        for (int t = 0; t < NT; t++) begin
            calc_tag[t] = pc_reg[TAG_BITS-1:0] ^ fold_tag_reg[t] ^ {fold_tag2_reg[t], 1'b0};
            if (tag_rd[t][TAG_BITS:1] == calc_tag[t]) begin
                hit_prov = 3'(t + 1);
                hit_dir  = tag_rd[t][EW-1 -: 3] > thbp_pkg::CTR_WEAK_NT;
            end
        end

        prov    = pend_prov_reg;
        pidx    = 2'(prov - 3'd1);
        cur_ctr = (prov == thbp_pkg::PROV_BIMODAL) ? bim_rd[2:0] : tag_rd[pidx][EW-1 -: 3];
        trained = cur_ctr;
        if (taken_reg && cur_ctr < thbp_pkg::CTR_MAX) begin
            trained = cur_ctr + 3'd1;
        end else if (!taken_reg && cur_ctr != 3'd0) begin
            trained = cur_ctr - 3'd1;
        end
        bim_ctr_t = (prov == thbp_pkg::PROV_BIMODAL) ? trained : bim_rd[2:0];
        bdir      = bim_ctr_t > thbp_pkg::CTR_WEAK_NT;

        alloc    = (guess_reg != taken_reg) && (prov < thbp_pkg::PROV_LAST);
        all_used = 1'b1;
        for (int i = 0; i < NT; i++) begin
            if (3'(i) >= prov && !tag_rd[i][0]) begin
                all_used = 1'b0;
            end
        end

        // offset = lfsr % (candidates), candidates = 4 - provider
        lfsr_adv = thbp_pkg::lfsr_step(lfsr_reg);
        case (prov)
            3'd0:    off = lfsr_adv[1:0];
            3'd1:    off = thbp_pkg::mod3_16(lfsr_adv);
            3'd2:    off = {1'b0, lfsr_adv[0]};
            default: off = 2'd0;
        endcase
        pick = prov + 3'(off);

        for (int i = 0; i < NT; i++) begin
            claim[i] = alloc && (3'(i) >= prov) &&
                       (all_used ? (pick == 3'(i)) : !tag_rd[i][0]);
        end
        claim_dir = bim_rd[3] ? taken_reg : bdir;

        useful_upd = (prov != thbp_pkg::PROV_BIMODAL) && (guess_reg != bdir);
        uval       = bdir != taken_reg;
    end

    // Write ports: clearing pass, or write-back of an update.
    always_comb begin
        bim_we = 1'b0;
        bim_wa = pc_reg[BI-1:0];
        bim_wd = {useful_upd ? uval : bim_rd[3], bim_ctr_t};
        if (state_reg == thbp_pkg::ST_CLEAR) begin
            bim_we = 1'b1;
            bim_wa = clr_reg[BI-1:0];
            bim_wd = {1'b0, thbp_pkg::CTR_WEAK_NT};
        end else if (look && op_reg == thbp_pkg::OP_UPDATE) begin
            bim_we = 1'b1;
        end

        for (int t = 0; t < NT; t++) begin
            tag_we[t] = 1'b0;
            tag_wa[t] = slot_reg[t];
            if (claim[t]) begin
                tag_wd[t] = {claim_dir ? thbp_pkg::CTR_WEAK_T : thbp_pkg::CTR_WEAK_NT,
                             calc_tag[t], 1'b0};
            end else begin
                tag_wd[t] = {trained, tag_rd[t][TAG_BITS:1],
                             useful_upd ? uval : tag_rd[t][0]};
            end
            if (state_reg == thbp_pkg::ST_CLEAR) begin
                tag_we[t] = 1'b1;
                tag_wa[t] = clr_reg[TI-1:0];
                tag_wd[t] = {thbp_pkg::CTR_WEAK_NT, {TAG_BITS{1'b0}}, 1'b0};
            end else if (look && op_reg == thbp_pkg::OP_UPDATE) begin
                tag_we[t] = claim[t] || (prov == 3'(t + 1));
            end
        end
    end

    // ------------------------------------------------------------------
    // Folded history next values (outcome shifted in)
    // ------------------------------------------------------------------
    for (genvar t = 0; t < NT; t++) begin : g_fold
        localparam int HL = LONGEST_HISTORY >> (NT - 1 - t);
        logic [TAG_BITS:0]   w0;
        logic [TAG_BITS-1:0] w1;
        logic [TI:0]         w2;
        assign w0 = {fold_tag_reg[t], taken_reg}
                  ^ ((TAG_BITS + 1)'(hist_reg[HL-1]) << (HL % TAG_BITS));
        assign w1 = {fold_tag2_reg[t], taken_reg}
                  ^ ((TAG_BITS)'(hist_reg[HL-1]) << (HL % (TAG_BITS - 1)));
        assign w2 = {fold_idx_reg[t], taken_reg}
                  ^ ((TI + 1)'(hist_reg[HL-1]) << (HL % TI));
        assign fold_tag_next[t]  = w0[TAG_BITS-1:0] ^ (TAG_BITS)'(w0[TAG_BITS]);
        assign fold_tag2_next[t] = w1[TAG_BITS-2:0] ^ (TAG_BITS - 1)'(w1[TAG_BITS-1]);
        assign fold_idx_next[t]  = w2[TI-1:0] ^ (TI)'(w2[TI]);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            thbp_pkg::ST_CLEAR: if (&clr_reg) state_next = thbp_pkg::ST_IDLE;
            thbp_pkg::ST_IDLE:  if (accept)   state_next = thbp_pkg::ST_LOOK;
            thbp_pkg::ST_LOOK:  state_next = thbp_pkg::ST_IDLE;
            default:            state_next = thbp_pkg::ST_CLEAR;
        endcase
    end

    // Item capture (payload, no reset) and result capture in the LOOK state
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_opcode;
            pc_reg    <= s_pc;
            taken_reg <= s_resolved_taken;
            guess_reg <= s_predicted_taken;
            for (int t = 0; t < NT; t++) begin
                slot_reg[t] <= rd_addr[t];
            end
        end
        if (look) begin
            m_taken_reg <= (op_reg == thbp_pkg::OP_UPDATE) ? guess_reg : hit_dir;
            m_prov_reg  <= (op_reg == thbp_pkg::OP_UPDATE) ? pend_prov_reg : hit_prov;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= thbp_pkg::ST_CLEAR;
            clr_reg       <= '0;
            hist_reg      <= '0;
            pend_prov_reg <= thbp_pkg::PROV_BIMODAL;
            pend_slot_reg <= '0;
            lfsr_reg      <= thbp_pkg::LFSR_SEED;
            m_valid_reg   <= 1'b0;
            for (int t = 0; t < NT; t++) begin
                fold_tag_reg[t]  <= '0;
                fold_tag2_reg[t] <= '0;
                fold_idx_reg[t]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == thbp_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (look) begin
                m_valid_reg <= 1'b1;
                if (op_reg == thbp_pkg::OP_PREDICT) begin
                    pend_prov_reg <= hit_prov;
                    pend_slot_reg <= (hit_prov == thbp_pkg::PROV_BIMODAL) ? '0
                                   : slot_reg[2'(hit_prov - 3'd1)];
                end else begin
                    hist_reg <= {hist_reg[LONGEST_HISTORY-2:0], taken_reg};
                    for (int t = 0; t < NT; t++) begin
                        fold_tag_reg[t]  <= fold_tag_next[t];
                        fold_tag2_reg[t] <= fold_tag2_next[t];
                        fold_idx_reg[t]  <= fold_idx_next[t];
                    end
                    if (alloc && all_used) begin
                        lfsr_reg <= lfsr_adv;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `THBP_ASSERT_NEXT(a_accept_to_look, accept, state_reg == thbp_pkg::ST_LOOK,
        "accepted transfer did not move to lookup")
    `THBP_ASSERT_NEXT(a_look_to_result, look, m_valid_reg,
        "lookup cycle did not load a result")
    `THBP_ASSERT_NOW(a_no_accept_in_clear, state_reg == thbp_pkg::ST_CLEAR, !s_ready,
        "input ready during clearing pass")
    `THBP_ASSERT_NOW(a_provider_range, m_valid_reg, m_prov_reg <= thbp_pkg::PROV_LAST,
        "provider code out of range")

endmodule
`default_nettype wire
